// ----- rtl/core/pq_table_distance_sum_top_defines.svh -----
// Assertion macros for the distance-sum engine checkers.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef PQ_TABLE_DISTANCE_SUM_TOP_DEFINES_SVH
`define PQ_TABLE_DISTANCE_SUM_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PQDS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PQDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/pqds_pkg.sv -----
// Shared widths, codes and types of the distance-sum engine.
// No dependencies; imported by every file but pqds_ram and the macro header.
package pqds_pkg;

  localparam int unsigned CFG_W       = 7;
  localparam int unsigned INDEX_W     = 14;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned GROUP_W     = 64;
  localparam int unsigned CODE_W      = 8;
  localparam int unsigned TAG_W       = 32;
  localparam int unsigned DIST_W      = 38;
  localparam int unsigned GROUP_BYTES = GROUP_W / CODE_W;

  localparam logic [CFG_W-1:0]  CFG_RESET = 7'd64;
  localparam logic [DIST_W-1:0] SUM_MAX   = {DIST_W{1'b1}};

  // Clock edges from accepting the final group to the first edge at which its result can be taken.
  localparam int unsigned RESULT_LATENCY = 7;
  // Result buffer entries; also the bound on results owed at any time.
  localparam int unsigned OUT_DEPTH      = 8;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_CODES = 1'b1
  } req_type_e;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [TAG_W-1:0] tag;
  } pqds_side_t;

endpackage

// ----- rtl/core/pqds_if.sv -----
// Valid/ready channel interfaces for input items and result items.
// Depends on pqds_pkg for the field widths.
interface pqds_in_if
  import pqds_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [INDEX_W-1:0] table_index;
  logic [VALUE_W-1:0] table_value;
  logic [GROUP_W-1:0] code_group;
  logic [TAG_W-1:0]   vector_tag;

  modport source (output valid, req_type, table_index, table_value, code_group, vector_tag,
                  input ready);
  modport sink   (input valid, req_type, table_index, table_value, code_group, vector_tag,
                  output ready);
endinterface

interface pqds_out_if
  import pqds_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic [TAG_W-1:0]  result_tag;

  modport source (output valid, distance, result_tag, input ready);
  modport sink   (input valid, distance, result_tag, output ready);
endinterface

// ----- rtl/core/pq_table_distance_sum_top.sv -----
// Product-quantization distance engine: banked table lookup in parallel lanes plus merge.
// Depends on pqds_pkg, pqds_if, pqds_lane and pqds_merge.
// One item per clock while ready is high, writes and code groups alike; one RAM bank per lane.
// A final group's distance goes through lane, bank, adder-tree and buffer registers.
// Ready drops only when 8 results are owed and not yet taken (size of the result buffer).
// Reset clears the pipeline, sum and group counter and sets num_subspaces to 64, not the table.
module pq_table_distance_sum_top
  import pqds_pkg::*;
#(
  parameter int unsigned MAX_SUBSPACES = 64,
  parameter int unsigned CODEBOOK_SIZE = 256,
  parameter int unsigned LANES         = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  pqds_in_if.sink          in_i,
  pqds_out_if.source       out_o
);

  localparam int unsigned TABLE_DEPTH = MAX_SUBSPACES * CODEBOOK_SIZE;
  localparam int unsigned ROWS        = (MAX_SUBSPACES + LANES - 1) / LANES;
  localparam int unsigned BANK_DEPTH  = ROWS * CODEBOOK_SIZE;
  localparam int unsigned BAW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int unsigned RW          = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned SUBW        = (MAX_SUBSPACES > 1) ? $clog2(MAX_SUBSPACES) : 1;
  localparam int unsigned LBW         = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned CNTW        = $clog2(MAX_SUBSPACES + 1);
  localparam int unsigned SW          = $clog2((MAX_SUBSPACES + 1) * (LANES + 1)) + 1;
  // Reciprocals for splitting a table index into subspace, bank and row; exact over the ranges.
  localparam int unsigned IDX_SHIFT   = 24;
  localparam int unsigned IDX_RECIP   = ((1 << IDX_SHIFT) + CODEBOOK_SIZE - 1) / CODEBOOK_SIZE;
  localparam int unsigned SUB_SHIFT   = 16;
  localparam int unsigned SUB_RECIP   = ((1 << SUB_SHIFT) + LANES - 1) / LANES;
  localparam int unsigned P1W         = INDEX_W + 21;
  localparam int unsigned P2W         = SUBW + 17;

  logic [CFG_W-1:0]   cfg_q;
  logic [SUBW-1:0]    gc_d;
  logic [SUBW-1:0]    gc_q;
  logic               acc;
  logic               is_code;
  logic               is_write;
  logic               in_ready;
  logic [CNTW-1:0]    count_eff;
  logic [SW-1:0]      base;
  logic               last_d;
  logic [LANES-1:0]   en_d;
  logic [CODE_W-1:0]  code_d [LANES];

  // Stage 1
  logic               wv1_q, rv1_q;
  logic [INDEX_W-1:0] idx1_q;
  logic [VALUE_W-1:0] val1_q;
  logic [CODE_W-1:0]  code1_q [LANES];
  logic [SUBW-1:0]    g1_q;
  logic [LANES-1:0]   en1_q;
  logic               last1_q;
  logic [TAG_W-1:0]   tag1_q;
  // Stage 2
  logic [P1W-1:0]     sub_prod;
  logic               wv2_q, rv2_q;
  logic [SUBW-1:0]    sub2_q;
  logic [INDEX_W-1:0] idx2_q;
  logic [VALUE_W-1:0] val2_q;
  logic [SUBW-1:0]    g2_q;
  logic [LANES-1:0]   en2_q;
  logic               last2_q;
  logic [TAG_W-1:0]   tag2_q;
  // Stage 3: bank access
  logic [P2W-1:0]     row_prod;
  logic               wv3_q, rv3_q;
  logic [RW-1:0]      row3_q;
  logic [SUBW-1:0]    sub3_q;
  logic [INDEX_W-1:0] idx3_q;
  logic [VALUE_W-1:0] val3_q;
  logic [SUBW-1:0]    g3_q;
  logic [LANES-1:0]   en3_q;
  logic               last3_q;
  logic [TAG_W-1:0]   tag3_q;
  logic [LBW-1:0]     bank3;
  logic [BAW-1:0]     waddr3;
  // Stage 4: data out of the banks
  pqds_side_t         side4_q;
  logic [LANES-1:0]   en4_q;
  logic [VALUE_W-1:0] rdata [LANES];

  assign acc      = in_i.valid && in_i.ready;
  assign is_code  = in_i.req_type == REQ_CODES;
  assign is_write = in_i.req_type == REQ_WRITE;

  always_comb begin
    if (cfg_q == '0) begin
      count_eff = CNTW'(1);
    end else if (32'(cfg_q) > MAX_SUBSPACES) begin
      count_eff = CNTW'(MAX_SUBSPACES);
    end else begin
      count_eff = CNTW'(cfg_q);
    end
    base   = SW'(gc_q) * SW'(LANES);
    last_d = (base + SW'(LANES)) >= SW'(count_eff);
    for (int j = 0; j < LANES; j++) begin
      en_d[j] = (base + SW'(j)) < SW'(count_eff);
    end
    gc_d = last_d ? '0 : gc_q + 1'b1;
  end

  // Lanes past the eighth byte of the code word look up codeword zero.
  for (genvar j = 0; j < LANES; j++) begin : g_code
    if (j < GROUP_BYTES) begin : g_byte
      assign code_d[j] = in_i.code_group[j*CODE_W +: CODE_W];
    end else begin : g_zero
      assign code_d[j] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= CFG_RESET;
      gc_q    <= '0;
      wv1_q   <= 1'b0;
      rv1_q   <= 1'b0;
      wv2_q   <= 1'b0;
      rv2_q   <= 1'b0;
      wv3_q   <= 1'b0;
      rv3_q   <= 1'b0;
      side4_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (acc && is_code) begin
        gc_q <= gc_d;
      end
      wv1_q   <= acc && is_write && (32'(in_i.table_index) < TABLE_DEPTH);
      rv1_q   <= acc && is_code;
      wv2_q   <= wv1_q;
      rv2_q   <= rv1_q;
      wv3_q   <= wv2_q;
      rv3_q   <= rv2_q;
      side4_q <= '{valid: rv3_q, last: last3_q, tag: tag3_q};
    end
  end

  assign sub_prod = P1W'(idx1_q) * P1W'(IDX_RECIP);
  assign row_prod = P2W'(sub2_q) * P2W'(SUB_RECIP);

  always_ff @(posedge clk_i) begin
    idx1_q  <= in_i.table_index;
    val1_q  <= in_i.table_value;
    code1_q <= code_d;
    g1_q    <= gc_q;
    en1_q   <= en_d;
    last1_q <= last_d;
    tag1_q  <= in_i.vector_tag;

    sub2_q  <= SUBW'(sub_prod >> IDX_SHIFT);
    idx2_q  <= idx1_q;
    val2_q  <= val1_q;
    g2_q    <= g1_q;
    en2_q   <= en1_q;
    last2_q <= last1_q;
    tag2_q  <= tag1_q;

    row3_q  <= RW'(row_prod >> SUB_SHIFT);
    sub3_q  <= sub2_q;
    idx3_q  <= idx2_q;
    val3_q  <= val2_q;
    g3_q    <= g2_q;
    en3_q   <= en2_q;
    last3_q <= last2_q;
    tag3_q  <= tag2_q;

    en4_q   <= en3_q;
  end

  // Subspace s lives in bank s mod LANES at row s div LANES.
  assign bank3  = LBW'(32'(sub3_q) - 32'(row3_q) * LANES);
  assign waddr3 = BAW'(32'(row3_q) * CODEBOOK_SIZE
                       + (32'(idx3_q) - 32'(sub3_q) * CODEBOOK_SIZE));

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    pqds_lane #(
      .MAX_SUBSPACES (MAX_SUBSPACES),
      .CODEBOOK_SIZE (CODEBOOK_SIZE),
      .LANES         (LANES)
    ) u_lane (
      .clk_i   (clk_i),
      .code_i  (code1_q[j]),
      .row_i   (RW'(g3_q)),
      .we_i    (wv3_q && (bank3 == LBW'(j))),
      .waddr_i (waddr3),
      .wdata_i (val3_q),
      .rdata_o (rdata[j])
    );
  end

  pqds_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .side_i  (side4_q),
    .en_i    (en4_q),
    .rdata_i (rdata),
    .claim_i (acc && is_code && last_d),
    .space_o (in_ready),
    .out_o   (out_o)
  );

  assign in_i.ready = in_ready;

endmodule

// ----- rtl/core/pqds_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pqds_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/pqds_lane.sv -----
// One lookup lane: reduces its codeword modulo the codebook size and reads its table bank.
// Depends on pqds_pkg and pqds_ram.
module pqds_lane
  import pqds_pkg::*;
#(
  parameter int unsigned MAX_SUBSPACES = 64,
  parameter int unsigned CODEBOOK_SIZE = 256,
  parameter int unsigned LANES         = 8,
  localparam int unsigned ROWS       = (MAX_SUBSPACES + LANES - 1) / LANES,
  localparam int unsigned BANK_DEPTH = ROWS * CODEBOOK_SIZE,
  localparam int unsigned BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1,
  localparam int unsigned RW         = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic               clk_i,
  input  logic [CODE_W-1:0]  code_i,
  input  logic [RW-1:0]      row_i,
  input  logic               we_i,
  input  logic [BAW-1:0]     waddr_i,
  input  logic [VALUE_W-1:0] wdata_i,
  output logic [VALUE_W-1:0] rdata_o
);

  // Reciprocal is exact for every 8-bit code at any codebook size up to 256.
  localparam int unsigned CODE_RECIP = ((1 << 16) + CODEBOOK_SIZE - 1) / CODEBOOK_SIZE;

  logic [23:0]       quot_prod;
  logic [15:0]       quot_back;
  logic [CODE_W-1:0] quot_q;
  logic [CODE_W-1:0] code_q;
  logic [CODE_W-1:0] rem_q;
  logic [BAW-1:0]    raddr;

  assign quot_prod = 24'(code_i) * 24'(CODE_RECIP);
  assign quot_back = 16'(quot_q) * 16'(CODEBOOK_SIZE);

  always_ff @(posedge clk_i) begin
    quot_q <= CODE_W'(quot_prod >> 16);
    code_q <= code_i;
    rem_q  <= CODE_W'(16'(code_q) - quot_back);
  end

  assign raddr = BAW'(32'(row_i) * 32'(CODEBOOK_SIZE) + 32'(rem_q));

  pqds_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (BANK_DEPTH)
  ) u_bank (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .raddr_i (raddr),
    .rdata_o (rdata_o)
  );

endmodule

// ----- rtl/core/pqds_merge.sv -----
// Merging stage: adder tree over the lanes, running sum with saturation, result buffer.
// Depends on pqds_pkg and the pqds_out_if interface.
module pqds_merge
  import pqds_pkg::*;
#(
  parameter int unsigned LANES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pqds_side_t         side_i,
  input  logic [LANES-1:0]   en_i,
  input  logic [VALUE_W-1:0] rdata_i [LANES],
  input  logic               claim_i,
  output logic               space_o,
  pqds_out_if.source         out_o
);

  localparam int unsigned NQ    = (LANES + 3) / 4;
  localparam int unsigned PW    = VALUE_W + 2;
  localparam int unsigned TW    = VALUE_W + $clog2(NQ) + 2;
  localparam int unsigned SUMW  = DIST_W + 1;
  localparam int unsigned PTRW  = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int unsigned LVW   = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [DIST_W-1:0] sum_val;
    logic [TAG_W-1:0]  tag;
  } result_t;

  logic [PW-1:0]     part_d [NQ];
  logic [PW-1:0]     part_q [NQ];
  logic [TW-1:0]     total_d;
  logic [TW-1:0]     total_q;
  pqds_side_t        side5_q;
  pqds_side_t        side6_q;
  logic [SUMW-1:0]   acc_sum;
  logic [DIST_W-1:0] sat_sum;
  logic [DIST_W-1:0] run_d;
  logic [DIST_W-1:0] run_q;
  logic              push;
  logic              pop;
  result_t           fifo_q [OUT_DEPTH];
  logic [PTRW-1:0]   wptr_q;
  logic [PTRW-1:0]   rptr_q;
  logic [LVW-1:0]    lvl_q;
  logic [LVW-1:0]    cnt_q;

  // First tree level: disabled lanes contribute nothing.
  always_comb begin
    for (int q = 0; q < NQ; q++) begin
      part_d[q] = '0;
    end
    for (int j = 0; j < LANES; j++) begin
      if (en_i[j]) begin
        part_d[j / 4] = part_d[j / 4] + PW'(rdata_i[j]);
      end
    end
  end

  always_comb begin
    total_d = '0;
    for (int q = 0; q < NQ; q++) begin
      total_d = total_d + TW'(part_q[q]);
    end
  end

  always_ff @(posedge clk_i) begin
    part_q  <= part_d;
    total_q <= total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side5_q <= '0;
      side6_q <= '0;
    end else begin
      side5_q <= side_i;
      side6_q <= side5_q;
    end
  end

  // All terms are non-negative, so clamping the running total once per group
  // matches clamping after every lane.
  assign acc_sum = {1'b0, run_q} + SUMW'(total_q);
  assign sat_sum = (acc_sum > {1'b0, SUM_MAX}) ? SUM_MAX : acc_sum[DIST_W-1:0];
  assign push    = side6_q.valid && side6_q.last;
  assign pop     = out_o.valid && out_o.ready;

  always_comb begin
    run_d = run_q;
    if (side6_q.valid) begin
      run_d = side6_q.last ? '0 : sat_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= '{sum_val: sat_sum, tag: side6_q.tag};
    end
  end

  // cnt_q counts results owed: claimed at input acceptance, released when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      lvl_q  <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PTRW'(OUT_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PTRW'(OUT_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      lvl_q <= lvl_q + LVW'(push) - LVW'(pop);
      cnt_q <= cnt_q + LVW'(claim_i) - LVW'(pop);
    end
  end

  assign space_o          = cnt_q < LVW'(OUT_DEPTH);
  assign out_o.valid      = lvl_q != '0;
  assign out_o.distance   = fifo_q[rptr_q].sum_val;
  assign out_o.result_tag = fifo_q[rptr_q].tag;

endmodule

// ----- rtl/core/pqds_checker.sv -----
// Port-level checks for the distance-sum engine, bound to the top level.
// Depends on pqds_pkg and the assertion macro header.
`include "pq_table_distance_sum_top_defines.svh"

module pqds_checker
  import pqds_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              in_req_type_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [DIST_W-1:0] out_distance_i,
  input logic [TAG_W-1:0]  out_tag_i
);

  // A waiting result keeps its value until it is taken.
  `PQDS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_distance_i) && $stable(out_tag_i), "result changed while stalled")

  // With nothing buffered at the output, the owed-result count cannot block input.
  `PQDS_ASSERT_SAME(a_ready_when_empty, !out_valid_i, in_ready_i, "input stalled with empty result buffer")

  // A result appearing on an empty output came from a code item accepted a fixed time earlier.
  `PQDS_ASSERT_SAME(a_result_origin, $rose(out_valid_i), $past(in_valid_i && in_ready_i && (in_req_type_i == REQ_CODES), RESULT_LATENCY), "result without a matching code item")

endmodule

bind pq_table_distance_sum_top pqds_checker u_pqds_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_req_type_i  (in_i.req_type),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_distance_i (out_o.distance),
  .out_tag_i      (out_o.result_tag)
);
